// File: design/ovn2d_pkg.sv
// Shared types and constants for the octave value noise block.
// Holds the controller step codes, the command struct and the register indexes.
// Depends on nothing; every design file of the block but ovn2d_checker imports it.
package ovn2d_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TABLE_AW   = 8;
  localparam int COORD_W    = 32;
  localparam int FREQ_W     = 24;
  localparam int OCTAVES_W  = 4;
  localparam int SEED_W     = 8;
  localparam int BYTE_W     = 8;
  localparam int OUT_W      = 16;
  localparam int DIV_CNT_W  = 4;
  localparam int OCT_CNT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int STEP_W     = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd2;

  // Controller steps; the controller state is the step it commands.
  localparam logic [STEP_W-1:0] ST_IDLE = 5'd0;
  localparam logic [STEP_W-1:0] ST_SCX  = 5'd1;
  localparam logic [STEP_W-1:0] ST_SCY  = 5'd2;
  localparam logic [STEP_W-1:0] ST_SCW  = 5'd3;
  localparam logic [STEP_W-1:0] ST_O0   = 5'd4;
  localparam logic [STEP_W-1:0] ST_O1   = 5'd5;
  localparam logic [STEP_W-1:0] ST_O2   = 5'd6;
  localparam logic [STEP_W-1:0] ST_O3   = 5'd7;
  localparam logic [STEP_W-1:0] ST_O4   = 5'd8;
  localparam logic [STEP_W-1:0] ST_O5   = 5'd9;
  localparam logic [STEP_W-1:0] ST_O6   = 5'd10;
  localparam logic [STEP_W-1:0] ST_O7   = 5'd11;
  localparam logic [STEP_W-1:0] ST_O8   = 5'd12;
  localparam logic [STEP_W-1:0] ST_O9   = 5'd13;
  localparam logic [STEP_W-1:0] ST_O10  = 5'd14;
  localparam logic [STEP_W-1:0] ST_DIV  = 5'd15;
  localparam logic [STEP_W-1:0] ST_OUT  = 5'd16;

  typedef struct packed {
    logic [STEP_W-1:0]    step;
    logic                 load;
    logic                 sample;
    logic [OCT_CNT_W-1:0] n;
  } ovn2d_cmd_t;

endpackage

// File: design/ovn2d_ctrl.sv
// Sequencing controller for the octave value noise block.
// Steps the datapath through scaling, the octaves and the division.
// Depends on ovn2d_pkg.
module ovn2d_ctrl
  import ovn2d_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 cmd,
  input  logic [OCTAVES_W-1:0] octaves,
  output logic                 busy,
  output logic                 noise_valid,
  output ovn2d_cmd_t           dp_cmd
);

  logic [STEP_W-1:0]    state;
  logic [STEP_W-1:0]    state_next;
  logic [OCT_CNT_W-1:0] n_reg;
  logic [OCT_CNT_W-1:0] oct_idx;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [OCT_CNT_W-1:0] n_sat;
  logic                 accept;
  logic                 last_octave;

  assign busy        = (state != ST_IDLE) && (state != ST_OUT);
  assign noise_valid = (state == ST_OUT);
  assign accept      = start && !busy;
  assign last_octave = (oct_idx == n_reg - OCT_CNT_W'(1));

  // Zero octaves behaves as one; too many are held at the maximum.
  always_comb begin
    if (octaves == '0) begin
      n_sat = OCT_CNT_W'(1);
    end else if (OCT_CNT_W'(octaves) > OCT_CNT_W'(MAX_OCTAVES)) begin
      n_sat = OCT_CNT_W'(MAX_OCTAVES);
    end else begin
      n_sat = OCT_CNT_W'(octaves);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state) inside
      ST_IDLE, ST_OUT: begin
        state_next = (accept && cmd) ? ST_SCX : ST_IDLE;
      end
      ST_SCX, ST_SCY, ST_SCW, ST_O0, ST_O1, ST_O2, ST_O3, ST_O4, ST_O5,
      ST_O6, ST_O7, ST_O8, ST_O9: begin
        state_next = state + STEP_W'(1);
      end
      ST_O10: begin
        state_next = last_octave ? ST_DIV : ST_O0;
      end
      ST_DIV: begin
        state_next = (div_cnt == '1) ? ST_OUT : ST_DIV;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      n_reg   <= OCT_CNT_W'(1);
      oct_idx <= '0;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept && cmd) begin
        n_reg   <= n_sat;
        oct_idx <= '0;
      end else if (state == ST_O10) begin
        oct_idx <= oct_idx + OCT_CNT_W'(1);
      end
      if (state == ST_DIV) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end else begin
        div_cnt <= '0;
      end
    end
  end

  always_comb begin
    dp_cmd.step   = state;
    dp_cmd.load   = accept && !cmd;
    dp_cmd.sample = accept && cmd;
    dp_cmd.n      = n_reg;
  end

endmodule

// File: design/ovn2d_datapath.sv
// Datapath of the octave value noise block: permutation table, shared multiplier,
// blend registers, octave accumulator and a restoring divider.
// Depends on ovn2d_pkg; driven step by step by ovn2d_ctrl.
module ovn2d_datapath
  import ovn2d_pkg::*;
#(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic              clk,
  input  ovn2d_cmd_t        dp_cmd,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic [BYTE_W-1:0] table_index,
  input  logic [BYTE_W-1:0] table_value,
  input  logic [FREQ_W-1:0] frequency,
  input  logic [SEED_W-1:0] seed,
  output logic [OUT_W-1:0]  noise_value
);

  localparam int F     = FRAC_BITS;
  localparam int K     = 8 + F;
  localparam int SUM_W = K + MAX_OCTAVES;
  localparam int MA    = (F + 9 > COORD_W + 1) ? F + 9 : COORD_W + 1;
  localparam int MB    = (F + 3 > FREQ_W + 1) ? F + 3 : FREQ_W + 1;
  localparam int PW    = MA + MB;
  localparam logic [F+1:0] THREE = (F + 2)'(3) << F;

  logic [BYTE_W-1:0] perm_mem [TABLE_SIZE];
  logic [BYTE_W-1:0] rd;
  logic [TABLE_AW-1:0] raddr;

  logic [COORD_W-1:0] cx, cy;
  logic [K-1:0]       px, py;
  logic [F-1:0]       qx, qy;
  logic [F:0]         wx, wy;
  logic [BYTE_W-1:0]  r0, r1, c00, c01;
  logic [K-1:0]       low, high;
  logic [SUM_W-1:0]   acc, den;
  logic [OUT_W-1:0]   quo;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_shr;

  logic [F-1:0]         sx, sy;
  logic [F+1:0]         tx, ty;
  logic [TABLE_AW-1:0]  xi, yi;
  logic signed [8:0]    d8;
  logic signed [K:0]    dhl;
  logic signed [K+1:0]  blend_c;
  logic signed [K+1:0]  blend_f;
  logic [MAX_OCTAVES-1:0] oct_mask;
  logic [SUM_W:0]       rem2, rem_diff;
  logic                 rem_ge;

  assign sx = px[F-1:0];
  assign sy = py[F-1:0];
  assign xi = px[F +: TABLE_AW];
  assign yi = py[F +: TABLE_AW];
  assign tx = THREE - {1'b0, sx, 1'b0};
  assign ty = THREE - {1'b0, sy, 1'b0};
  assign prod_shr = prod >>> F;
  assign dhl = $signed({1'b0, high}) - $signed({1'b0, low});
  assign noise_value = quo;

  // Corner differences come straight from the read port; rd holds the later corner.
  always_comb begin
    if (dp_cmd.step == ST_O5) begin
      d8 = $signed({1'b0, rd}) - $signed({1'b0, c00});
    end else begin
      d8 = $signed({1'b0, rd}) - $signed({1'b0, c01});
    end
  end

  // The first two blends carry the byte difference times the weight with no scaling.
  always_comb begin
    if (dp_cmd.step == ST_O6) begin
      blend_c = $signed({2'b0, c00, {F{1'b0}}}) + $signed(prod[K+1:0]);
    end else begin
      blend_c = $signed({2'b0, c01, {F{1'b0}}}) + $signed(prod[K+1:0]);
    end
  end

  assign blend_f = $signed({2'b0, low}) + $signed(prod_shr[K+1:0]);

  always_comb begin
    for (int b = 0; b < MAX_OCTAVES; b++) begin
      oct_mask[b] = (OCT_CNT_W'(b) < dp_cmd.n);
    end
  end

  assign rem2     = {acc, 1'b0};
  assign rem_ge   = (rem2 >= {1'b0, den});
  assign rem_diff = rem2 - {1'b0, den};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (dp_cmd.step)
      ST_SCX: begin
        mul_a = $signed(MA'(cx));
        mul_b = $signed(MB'(frequency));
      end
      ST_SCY: begin
        mul_a = $signed(MA'(cy));
        mul_b = $signed(MB'(frequency));
      end
      ST_O0: begin
        mul_a = $signed(MA'(sx));
        mul_b = $signed(MB'(sx));
      end
      ST_O1: begin
        mul_a = $signed(MA'(sy));
        mul_b = $signed(MB'(sy));
      end
      ST_O2: begin
        mul_a = $signed(MA'(qx));
        mul_b = $signed(MB'(tx));
      end
      ST_O3: begin
        mul_a = $signed(MA'(qy));
        mul_b = $signed(MB'(ty));
      end
      ST_O5, ST_O7: begin
        mul_a = MA'(d8);
        mul_b = $signed(MB'(wx));
      end
      ST_O9: begin
        mul_a = MA'(dhl);
        mul_b = $signed(MB'(wy));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Row reads first, then the four corners; the table wraps at 256 entries.
  // Each read is registered and lands in rd in the cycle after its address.
  always_comb begin
    case (dp_cmd.step)
      ST_O0:   raddr = yi + seed;
      ST_O1:   raddr = yi + seed + TABLE_AW'(1);
      ST_O3:   raddr = r0 + xi;
      ST_O4:   raddr = r0 + xi + TABLE_AW'(1);
      ST_O5:   raddr = r1 + xi;
      ST_O6:   raddr = r1 + xi + TABLE_AW'(1);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      perm_mem[table_index] <= table_value;
    end
    rd <= perm_mem[raddr];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.sample) begin
      cx  <= coord_x;
      cy  <= coord_y;
      acc <= '0;
    end
    case (dp_cmd.step)
      ST_SCX: begin
        den <= {oct_mask, {K{1'b0}}};
      end
      ST_SCY: begin
        px <= prod[COORD_W-F +: K];
      end
      ST_SCW: begin
        py <= prod[COORD_W-F +: K];
      end
      ST_O1: begin
        qx <= prod[F +: F];
        r0 <= rd;
      end
      ST_O2: begin
        qy <= prod[F +: F];
        r1 <= rd;
      end
      ST_O3: begin
        wx <= prod[F +: F+1];
      end
      ST_O4: begin
        wy  <= prod[F +: F+1];
        c00 <= rd;
      end
      ST_O6: begin
        low <= blend_c[K-1:0];
        c01 <= rd;
      end
      ST_O8: begin
        high <= blend_c[K-1:0];
      end
      ST_O10: begin
        acc <= {acc[SUM_W-2:0], 1'b0} + SUM_W'(blend_f[K-1:0]);
        px  <= {px[K-2:0], 1'b0};
        py  <= {py[K-2:0], 1'b0};
      end
      ST_DIV: begin
        if (rem_ge) begin
          acc <= rem_diff[SUM_W-1:0];
        end else begin
          acc <= rem2[SUM_W-1:0];
        end
        quo <= {quo[OUT_W-2:0], rem_ge};
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/octave_value_noise_2d.sv
// Top level of the fractal two-dimensional value noise block.
// Holds the configuration registers and joins ovn2d_ctrl to ovn2d_datapath.
// Depends on ovn2d_pkg, ovn2d_ctrl and ovn2d_datapath.
//
// Usage. A transaction is accepted at a rising edge with start high and busy low.
// With cmd low it writes table_value into permutation entry table_index; this
// produces no result and leaves busy low, so loads may follow every cycle.
// Every table entry must be loaded before the first sample is requested.
// With cmd high it samples the noise at (coord_x, coord_y), both unsigned Q16.16.
// Configuration (frequency, octaves, seed) is written through cfg_we, cfg_index
// and cfg_data; the user must do so only while no sample is in flight, as the block
// does not enforce it; indexes past the list are ignored. A sample goes from
// acceptance to result in steps, with n the octave count clamped to 1..MAX_OCTAVES:
// the point is scaled, then the n octaves run at a pace set by the single shared
// multiplier and one table read port; the divider gives one quotient bit a cycle.
// noise_valid is high for exactly one cycle with the result on noise_value.
// busy is low again in that cycle, so the next transaction can be accepted in
// the cycle that shows the result; the receiver cannot stall it.
// Synchronous reset returns the controller to idle and the registers to their
// defaults (frequency 1.0, four octaves, seed zero); the table keeps no reset.
module octave_value_noise_2d
  import ovn2d_pkg::*;
#(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cmd,
  input  logic [COORD_W-1:0]    coord_x,
  input  logic [COORD_W-1:0]    coord_y,
  input  logic [BYTE_W-1:0]     table_index,
  input  logic [BYTE_W-1:0]     table_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [OUT_W-1:0]      noise_value,
  output logic                  noise_valid
);

  logic [FREQ_W-1:0]    frequency;
  logic [OCTAVES_W-1:0] octaves;
  logic [SEED_W-1:0]    seed;
  ovn2d_cmd_t           dp_cmd;

  // Configuration registers. Each write replaces one whole register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frequency <= FREQ_W'(65536);
      octaves   <= OCTAVES_W'(4);
      seed      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FREQUENCY: frequency <= cfg_data[FREQ_W-1:0];
        CFG_OCTAVES:   octaves   <= cfg_data[OCTAVES_W-1:0];
        CFG_SEED:      seed      <= cfg_data[SEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller owns the handshake and sequences the datapath.
  ovn2d_ctrl #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .octaves     (octaves),
    .busy        (busy),
    .noise_valid (noise_valid),
    .dp_cmd      (dp_cmd)
  );

  // The datapath holds the table, the arithmetic and the result register.
  ovn2d_datapath #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .dp_cmd      (dp_cmd),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .table_index (table_index),
    .table_value (table_value),
    .frequency   (frequency),
    .seed        (seed),
    .noise_value (noise_value)
  );

endmodule

// File: design/ovn2d_checker.sv
// Port-level checks for the octave value noise block, bound to the top level.
// Watches the command handshake and the result strobe over time.
// Depends on the port names of octave_value_noise_2d only.
module ovn2d_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cmd,
  input logic noise_valid
);

  // A sample runs through all its steps before its result, so two results never come back to back.
  a_no_double_result: assert property (@(posedge clk) disable iff (rst)
    noise_valid |=> !noise_valid)
    else $error("result strobe high in two consecutive cycles");

  // An accepted sample transaction makes the block busy in the next cycle.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd) |=> busy)
    else $error("sample accepted but block not busy afterwards");

  // A table load gives no result and leaves the block free.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cmd) |=> (!noise_valid && !busy))
    else $error("table load produced a result or made the block busy");

  // The block only leaves its busy phase by delivering a result.
  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> noise_valid)
    else $error("busy fell without a result");

  // No result is shown while a sample is still being worked on.
  a_result_not_busy: assert property (@(posedge clk) disable iff (rst)
    noise_valid |-> !busy)
    else $error("result strobe while busy");

endmodule

bind octave_value_noise_2d ovn2d_checker u_checker (.*);
